// ===== sv/lra_pkg.sv =====
`timescale 1ns / 1ps

package lra_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int NUM_WREGS = 8;
	localparam int WREG_IDX_W = 3;
	localparam int WEIGHT_W = 16;
	localparam int BUDGET_W = 16;
	localparam int SHARE_W = 16;
	localparam int SLOT_IDX_W = 3;
	localparam int PROD_W = BUDGET_W + WEIGHT_W;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [SHARE_W-1:0] share_t;

endpackage

// ===== sv/largest_remainder_apportioner_core.sv =====
`timescale 1ns / 1ps
// Sums the weights over the SLOTS slots, then per slot runs one multiply and a
// 32-step restoring division, then up to SLOTS-1 passes to hand out the leftover points,
// then SLOTS output beats; a zero weight total or zero budget goes straight to zero beats.
// One item at a time: the next budget is taken after the last beat leaves.
// Reset (arst_n low) clears all weights to zero.
module largest_remainder_apportioner_core
	import lra_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BUDGET_W-1:0]   budget,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic [SHARE_W-1:0]    share,
	output logic                  last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TOTAL_W = WEIGHT_W + $clog2(SLOTS);
	localparam int CNT_W = $clog2(PROD_W);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PROD_W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PICK = 3'd4;
	localparam logic [2:0] ST_GIVE = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]          state_q;
	weight_t             w_q [NUM_WREGS];
	logic [BUDGET_W-1:0] budget_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TOTAL_W-1:0]  rem_q;
	share_t              quot_q;
	share_t              assigned_q;
	share_t              leftover_q;
	share_t              share_q [SLOTS];
	logic [TOTAL_W-1:0]  resid_q [SLOTS];
	logic [SLOTS-1:0]    taken_q;
	logic                zero_q;
	logic                found_q;
	logic [IDX_W-1:0]    best_q;
	logic [TOTAL_W-1:0]  best_res_q;

	// one restoring division step
	logic [TOTAL_W:0]    trial;
	logic                q_bit;
	logic [TOTAL_W-1:0]  rem_next;
	share_t              quot_next;
	logic [TOTAL_W-1:0]  total_next;
	weight_t             w_cur;
	logic                eligible;

	assign w_cur = w_q[WREG_IDX_W'(idx_q)];
	assign trial = {rem_q, prod_q[PROD_W-1]};
	assign q_bit = (trial >= {1'b0, total_q});
	assign rem_next = q_bit ? TOTAL_W'(trial - {1'b0, total_q}) : TOTAL_W'(trial);
	assign quot_next = {quot_q[SHARE_W-2:0], q_bit};
	assign total_next = total_q + TOTAL_W'(w_cur);
	assign eligible = (w_cur != '0) && !taken_q[idx_q];

	assign pready = 1'b1;
	assign prdata = DATA_W'(w_q[paddr[ADDR_W-1:2]]);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign slot_index = SLOT_IDX_W'(idx_q);
	assign share = zero_q ? '0 : share_q[idx_q];
	assign last = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WREGS; i++) begin
				w_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			w_q[paddr[ADDR_W-1:2]] <= pwdata[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			taken_q <= '0;
			zero_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SUM;
						idx_q <= '0;
						taken_q <= '0;
						zero_q <= 1'b0;
					end
				end
				ST_SUM: begin
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						if (total_next == '0 || budget_q == '0) begin
							zero_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						if (idx_q == LAST_IDX) begin
							idx_q <= '0;
							found_q <= 1'b0;
							// leftover is at most SLOTS-1
							state_q <= (budget_q == assigned_q + quot_next) ? ST_OUT : ST_PICK;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_PICK: begin
					if (eligible && (!found_q || resid_q[idx_q] > best_res_q)) begin
						found_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						state_q <= ST_GIVE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_GIVE: begin
					found_q <= 1'b0;
					if (found_q) begin
						taken_q[best_q] <= 1'b1;
					end
					if (!found_q || leftover_q == share_t'(1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PICK;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (idx_q == LAST_IDX) begin
							idx_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				budget_q <= budget;
				total_q <= '0;
				assigned_q <= '0;
			end
			ST_SUM: begin
				total_q <= total_next;
			end
			ST_MUL: begin
				prod_q <= budget_q * w_cur;
				rem_q <= '0;
				quot_q <= '0;
			end
			ST_DIV: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				rem_q <= rem_next;
				quot_q <= quot_next;
				if (cnt_q == LAST_BIT) begin
					share_q[idx_q] <= quot_next;
					resid_q[idx_q] <= rem_next;
					assigned_q <= assigned_q + quot_next;
					leftover_q <= budget_q - (assigned_q + quot_next);
				end
			end
			ST_PICK: begin
				// strict compare keeps the lower index on ties
				if (eligible && (!found_q || resid_q[idx_q] > best_res_q)) begin
					best_q <= idx_q;
					best_res_q <= resid_q[idx_q];
				end
			end
			ST_GIVE: begin
				if (found_q) begin
					share_q[best_q] <= share_q[best_q] + 1'b1;
					leftover_q <= leftover_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
